FILE: design/sbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_pkg: shared types, tables and functions of the 128-bit block cipher
// Holds the substitution tables, the GF(2^8) arithmetic of the linear layer,
// the controller state and command types.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int unsigned BLOCK_W  = 128;
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned NUM_KEYS = 4;
   localparam int unsigned NUM_RK   = 10;
   localparam int unsigned CNT_W    = 5;
   localparam int unsigned RK_IDX_W = 4;
   localparam int unsigned CSR_IDX_W = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD0 = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD1 = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD2 = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD3 = 8'd3;

   localparam logic [CNT_W-1:0] KS_STEP_LAST = 5'd31;
   localparam logic [CNT_W-1:0] ROUND_LAST   = 5'd9;
   localparam logic [7:0]       GF_POLY      = 8'hC3;

   typedef enum logic [1:0] {
      ST_EXP_LOAD,
      ST_EXPAND,
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic             load_key;
      logic             ks_step;
      logic             load_data;
      logic             round_step;
      logic             finish;
      logic [CNT_W-1:0] cnt;
   } cmd_type;

   typedef logic [BLOCK_W-1:0][BLOCK_W-1:0] lmat_type;
   typedef logic [31:0][BLOCK_W-1:0]        rconst_type;

   localparam logic [7:0] LIN_COEF [16] = '{
      8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
      8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1};

   localparam logic [7:0] SBOX_FWD [256] = '{
      8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
      8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
      8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
      8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
      8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
      8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
      8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
      8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
      8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
      8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
      8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
      8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
      8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
      8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
      8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
      8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6};

   localparam logic [7:0] SBOX_INV [256] = '{
      8'hA5,8'h2D,8'h32,8'h8F,8'h0E,8'h30,8'h38,8'hC0,8'h54,8'hE6,8'h9E,8'h39,8'h55,8'h7E,8'h52,8'h91,
      8'h64,8'h03,8'h57,8'h5A,8'h1C,8'h60,8'h07,8'h18,8'h21,8'h72,8'hA8,8'hD1,8'h29,8'hC6,8'hA4,8'h3F,
      8'hE0,8'h27,8'h8D,8'h0C,8'h82,8'hEA,8'hAE,8'hB4,8'h9A,8'h63,8'h49,8'hE5,8'h42,8'hE4,8'h15,8'hB7,
      8'hC8,8'h06,8'h70,8'h9D,8'h41,8'h75,8'h19,8'hC9,8'hAA,8'hFC,8'h4D,8'hBF,8'h2A,8'h73,8'h84,8'hD5,
      8'hC3,8'hAF,8'h2B,8'h86,8'hA7,8'hB1,8'hB2,8'h5B,8'h46,8'hD3,8'h9F,8'hFD,8'hD4,8'h0F,8'h9C,8'h2F,
      8'h9B,8'h43,8'hEF,8'hD9,8'h79,8'hB6,8'h53,8'h7F,8'hC1,8'hF0,8'h23,8'hE7,8'h25,8'h5E,8'hB5,8'h1E,
      8'hA2,8'hDF,8'hA6,8'hFE,8'hAC,8'h22,8'hF9,8'hE2,8'h4A,8'hBC,8'h35,8'hCA,8'hEE,8'h78,8'h05,8'h6B,
      8'h51,8'hE1,8'h59,8'hA3,8'hF2,8'h71,8'h56,8'h11,8'h6A,8'h89,8'h94,8'h65,8'h8C,8'hBB,8'h77,8'h3C,
      8'h7B,8'h28,8'hAB,8'hD2,8'h31,8'hDE,8'hC4,8'h5F,8'hCC,8'hCF,8'h76,8'h2C,8'hB8,8'hD8,8'h2E,8'h36,
      8'hDB,8'h69,8'hB3,8'h14,8'h95,8'hBE,8'h62,8'hA1,8'h3B,8'h16,8'h66,8'hE9,8'h5C,8'h6C,8'h6D,8'hAD,
      8'h37,8'h61,8'h4B,8'hB9,8'hE3,8'hBA,8'hF1,8'hA0,8'h85,8'h83,8'hDA,8'h47,8'hC5,8'hB0,8'h33,8'hFA,
      8'h96,8'h6F,8'h6E,8'hC2,8'hF6,8'h50,8'hFF,8'h5D,8'hA9,8'h8E,8'h17,8'h1B,8'h97,8'h7D,8'hEC,8'h58,
      8'hF7,8'h1F,8'hFB,8'h7C,8'h09,8'h0D,8'h7A,8'h67,8'h45,8'h87,8'hDC,8'hE8,8'h4F,8'h1D,8'h4E,8'h04,
      8'hEB,8'hF8,8'hF3,8'h3E,8'h3D,8'hBD,8'h8A,8'h88,8'hDD,8'hCD,8'h0B,8'h13,8'h98,8'h02,8'h93,8'h80,
      8'h90,8'hD0,8'h24,8'h34,8'hCB,8'hED,8'hF4,8'hCE,8'h99,8'h10,8'h44,8'h40,8'h92,8'h3A,8'h01,8'h26,
      8'h12,8'h1A,8'h48,8'h68,8'hF5,8'h81,8'h8B,8'hC7,8'hD6,8'h20,8'h0A,8'h08,8'h00,8'h4C,8'hD7,8'h74};

   // Multiply in GF(2^8) modulo x^8+x^7+x^6+x+1.
   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = '0;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
      end
      return p;
   endfunction

   // One output byte of the linear feedback; byte 0 sits in the top bits.
   function automatic logic [7:0] lin_fold(logic [BLOCK_W-1:0] v);
      logic [7:0] acc;
      acc = '0;
      for (int i = 0; i < 16; i++) acc = acc ^ gf_mul(v[BLOCK_W-1-8*i -: 8], LIN_COEF[i]);
      return acc;
   endfunction

   function automatic logic [BLOCK_W-1:0] lin_fwd(logic [BLOCK_W-1:0] v_in);
      logic [BLOCK_W-1:0] v;
      v = v_in;
      for (int i = 0; i < 16; i++) v = {lin_fold(v), v[BLOCK_W-1:8]};
      return v;
   endfunction

   function automatic logic [BLOCK_W-1:0] lin_back(logic [BLOCK_W-1:0] v_in);
      logic [BLOCK_W-1:0] v;
      v = v_in;
      for (int i = 0; i < 16; i++) begin
         v = {v[BLOCK_W-9:0], v[BLOCK_W-1 -: 8]};
         v[7:0] = lin_fold(v);
      end
      return v;
   endfunction

   // The linear layers are GF(2)-linear: tabulate the image of each input bit.
   function automatic lmat_type build_lfwd();
      lmat_type m;
      for (int i = 0; i < BLOCK_W; i++) m[i] = lin_fwd(BLOCK_W'(1) << i);
      return m;
   endfunction

   function automatic lmat_type build_lback();
      lmat_type m;
      for (int i = 0; i < BLOCK_W; i++) m[i] = lin_back(BLOCK_W'(1) << i);
      return m;
   endfunction

   function automatic rconst_type build_rconst();
      rconst_type r;
      for (int s = 0; s < 32; s++) r[s] = lin_fwd({120'b0, 8'(s + 1)});
      return r;
   endfunction

   function automatic logic [BLOCK_W-1:0] l_apply(lmat_type m, logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] r;
      r = '0;
      for (int i = 0; i < BLOCK_W; i++) if (v[i]) r = r ^ m[i];
      return r;
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_fwd(logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] r;
      for (int k = 0; k < 16; k++) r[8*k +: 8] = SBOX_FWD[v[8*k +: 8]];
      return r;
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_inv(logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] r;
      for (int k = 0; k < 16; k++) r[8*k +: 8] = SBOX_INV[v[8*k +: 8]];
      return r;
   endfunction

endpackage

FILE: design/sbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_ctrl: sequencer of the block cipher
// Runs the key schedule after reset and after key writes, and steps the
// round unit through the nine rounds and final key addition of each request.
// ----------------------------------------------------------------------------
module sbc_ctrl
   import sbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    key_write,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    out_free,
   output cmd_type cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pending_ff, pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_EXP_LOAD;
         cnt_ff     <= '0;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         pending_ff <= pending_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      pending_in = pending_ff | key_write;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.cnt    = cnt_ff;
      unique case (state_ff)
         ST_EXP_LOAD: begin
            cmd.load_key = 1'b1;
            cnt_in       = '0;
            pending_in   = key_write;
            state_in     = ST_EXPAND;
         end
         ST_EXPAND: begin
            cmd.ks_step = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == KS_STEP_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = !pending_ff;
            if (pending_ff) begin
               state_in = ST_EXP_LOAD;
            end else if (req_tvalid) begin
               cmd.load_data = 1'b1;
               cnt_in        = '0;
               state_in      = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff != ROUND_LAST) begin
               cmd.round_step = 1'b1;
               cnt_in         = cnt_ff + 1'b1;
            end else if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_EXP_LOAD;
      endcase
   end

`ifndef SYNTHESIS
   a_run_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> cnt_ff <= ROUND_LAST)
      else $error("round counter past last round");
   a_key_blocks: assert property (@(posedge clock) disable iff (reset)
      key_write |=> !req_tready)
      else $error("request taken before key schedule rerun");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free && cnt_ff == ROUND_LAST)
      else $error("result written over a waiting response");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_key, cmd.ks_step, cmd.load_data, cmd.round_step, cmd.finish}))
      else $error("conflicting datapath commands");
`endif

endmodule

FILE: design/sbc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_datapath: key registers, round key store, round unit and response reg
// One round unit computes L(S(x ^ k)) or S^-1(L^-1(x ^ k)) per cycle and is
// shared by the key schedule and the data rounds.
// ----------------------------------------------------------------------------
module sbc_datapath
   import sbc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  logic                 key_write,
   input  logic [1:0]           key_sel,
   input  logic [WORD_W-1:0]    key_data,
   input  logic                 req_mode,
   input  logic [BLOCK_W-1:0]   req_block,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BLOCK_W-1:0]   rsp_block
);

   localparam lmat_type   LFWD   = build_lfwd();
   localparam lmat_type   LBACK  = build_lback();
   localparam rconst_type RCONST = build_rconst();

   logic [WORD_W-1:0]   key_ff [NUM_KEYS];
   logic [BLOCK_W-1:0]  rk_ff [NUM_RK];
   logic [BLOCK_W-1:0]  a_ff, a_in;
   logic [BLOCK_W-1:0]  b_ff, b_in;
   logic                mode_ff, mode_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]  rsp_block_ff;
   logic [RK_IDX_W-1:0] rk_sel, rk_wr;
   logic [BLOCK_W-1:0]  kx, x, fwd, inv;

   assign rk_sel = mode_ff ? RK_IDX_W'(ROUND_LAST - cmd.cnt) : cmd.cnt[RK_IDX_W-1:0];
   assign rk_wr  = RK_IDX_W'({cmd.cnt[4:3], 1'b0}) + RK_IDX_W'(2);
   assign kx     = cmd.ks_step ? RCONST[cmd.cnt] : rk_ff[rk_sel];
   assign x      = a_ff ^ kx;
   assign fwd    = l_apply(LFWD, sub_fwd(x));
   assign inv    = sub_inv(l_apply(LBACK, x));

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_block = rsp_block_ff;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      mode_in = mode_ff;
      if (cmd.load_key) begin
         a_in = {key_ff[0], key_ff[1]};
         b_in = {key_ff[2], key_ff[3]};
      end else if (cmd.ks_step) begin
         a_in = fwd ^ b_ff;
         b_in = a_ff;
      end else if (cmd.load_data) begin
         a_in    = req_block;
         mode_in = req_mode;
      end else if (cmd.round_step) begin
         a_in = mode_ff ? inv : fwd;
      end
      rsp_valid_in = cmd.finish | (rsp_valid_ff & !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_KEYS; i++) key_ff[i] <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (key_write) key_ff[key_sel] <= key_data;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      mode_ff <= mode_in;
      if (cmd.finish) rsp_block_ff <= x;
      if (cmd.load_key) begin
         rk_ff[0] <= {key_ff[0], key_ff[1]};
         rk_ff[1] <= {key_ff[2], key_ff[3]};
      end else if (cmd.ks_step && cmd.cnt[2:0] == 3'd7) begin
         rk_ff[rk_wr]                    <= fwd ^ b_ff;
         rk_ff[rk_wr + RK_IDX_W'(1)]     <= a_ff;
      end
   end

endmodule

FILE: design/sp_block_cipher_128_encrypt_decrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sp_block_cipher_128_encrypt_decrypt: 10-round 128-bit SPN cipher
// Encrypts or decrypts one 128-bit block per request under a 256-bit key.
// ----------------------------------------------------------------------------
// A request is loaded at the accepting edge; then nine rounds and one final
// key addition run on the single round unit before the response register is
// loaded. The controller returns to idle only after that, so no new request
// is accepted while one is in flight; the next request can be accepted on the
// cycle after the response register is loaded, while that response may still
// be waiting. The final key addition waits while a previous response has not
// been taken. The key is written through the csr port (index 0 to 3, 64 bits
// each, byte 0 of each word in the top bits); indexes above 3 are ignored.
// After reset and after any key write the block runs the key schedule, using
// the same round unit for its 32 Feistel steps, and accepts no request until
// the schedule is done. The user must make key writes only while no request
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sp_block_cipher_128_encrypt_decrypt
   import sbc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BLOCK_W-1:0]   req_tdata,   // in_hi [63:0], in_lo [127:64]
   input  logic                 req_tuser,   // mode: 0 encrypt, 1 decrypt
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BLOCK_W-1:0]   rsp_tdata,   // out_hi [63:0], out_lo [127:64]
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data
);

   cmd_type            cmd;
   logic               out_free;
   logic               key_write;
   logic [BLOCK_W-1:0] rsp_block;

   // Key registers accept a write at any time; only the four key indexes act.
   assign csr_ready = 1'b1;
   assign key_write = csr_valid && (csr_index == CSR_KEY_WORD0 || csr_index == CSR_KEY_WORD1 ||
                      csr_index == CSR_KEY_WORD2 || csr_index == CSR_KEY_WORD3);

   sbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .key_write  (key_write),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (out_free),
      .cmd        (cmd)
   );

   // The block is held with byte 0 in the top bits: {in_hi, in_lo}.
   sbc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .key_write (key_write),
      .key_sel   (csr_index[1:0]),
      .key_data  (csr_data),
      .req_mode  (req_tuser),
      .req_block ({req_tdata[WORD_W-1:0], req_tdata[BLOCK_W-1:WORD_W]}),
      .out_free  (out_free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_block (rsp_block)
   );

   assign rsp_tdata = {rsp_block[WORD_W-1:0], rsp_block[BLOCK_W-1:WORD_W]};

endmodule

FILE: tb/tb_sp_block_cipher_128_encrypt_decrypt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cipher checker
// Watches the key writes, the requests and the responses of the block cipher,
// computes each expected output block and compares it with the response.
// ----------------------------------------------------------------------------
module tb_sp_block_cipher_128_encrypt_decrypt_checker
   import sbc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [BLOCK_W-1:0]   req_tdata,
   input  logic                 req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [BLOCK_W-1:0]   rsp_tdata,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data,
   output int                   error_count,
   output int                   blocks_pending
);

   localparam byte unsigned COEF [16] = '{148, 32, 133, 16, 194, 192, 1, 251,
                                          1, 192, 194, 16, 133, 32, 148, 1};

   // Blocks are held with byte 0 in the top bits.
   logic [WORD_W-1:0]  key_words [4];
   logic [BLOCK_W-1:0] round_keys [10];
   logic               schedule_stale;
   logic [BLOCK_W-1:0] expected_blocks [$];

   function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'hC3 : 8'h00);
      end
      return p;
   endfunction

   function automatic logic [7:0] mix_byte(logic [BLOCK_W-1:0] v);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 16; i++) acc ^= field_mul(v[127-8*i -: 8], COEF[i]);
      return acc;
   endfunction

   function automatic logic [BLOCK_W-1:0] mix_forward(logic [BLOCK_W-1:0] v);
      for (int i = 0; i < 16; i++) v = {mix_byte(v), v[127:8]};
      return v;
   endfunction

   function automatic logic [BLOCK_W-1:0] mix_backward(logic [BLOCK_W-1:0] v);
      for (int i = 0; i < 16; i++) begin
         v = {v[119:0], v[127:120]};
         v[7:0] = mix_byte(v);
      end
      return v;
   endfunction

   function automatic logic [BLOCK_W-1:0] substitute(logic [BLOCK_W-1:0] v, bit inv);
      for (int k = 0; k < 16; k++)
         v[8*k +: 8] = inv ? SBOX_INV[v[8*k +: 8]] : SBOX_FWD[v[8*k +: 8]];
      return v;
   endfunction

   // Key schedule: 32 Feistel steps with the mixed round constants.
   function automatic void expand_schedule();
      logic [BLOCK_W-1:0] a, b, t, c;
      a = {key_words[0], key_words[1]};
      b = {key_words[2], key_words[3]};
      round_keys[0] = a;
      round_keys[1] = b;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 8; j++) begin
            c = mix_forward({120'b0, 8'(8 * i + j + 1)});
            t = mix_forward(substitute(a ^ c, 1'b0)) ^ b;
            b = a;
            a = t;
         end
         round_keys[2*i+2] = a;
         round_keys[2*i+3] = b;
      end
      schedule_stale = 1'b0;
   endfunction

   function automatic logic [BLOCK_W-1:0] cipher_block(logic [BLOCK_W-1:0] v, bit decrypt);
      if (!decrypt) begin
         for (int r = 0; r < 9; r++) v = mix_forward(substitute(v ^ round_keys[r], 1'b0));
         v ^= round_keys[9];
      end else begin
         for (int r = 9; r > 0; r--) v = substitute(mix_backward(v ^ round_keys[r]), 1'b1);
         v ^= round_keys[0];
      end
      return v;
   endfunction

   assign blocks_pending = expected_blocks.size();

   always @(posedge clock) begin
      logic [BLOCK_W-1:0] want, got;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_words[i] = '0;
         schedule_stale = 1'b1;
         expected_blocks.delete();
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready && csr_index < 4) begin
            key_words[csr_index[1:0]] = csr_data;
            schedule_stale = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            if (schedule_stale) expand_schedule();
            expected_blocks.push_back(cipher_block({req_tdata[63:0], req_tdata[127:64]},
                                                   req_tuser));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[63:0], rsp_tdata[127:64]};
            if (expected_blocks.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response %h", $time, got);
            end else begin
               want = expected_blocks.pop_front();
               if (want[127:64] != got[127:64]) begin
                  error_count++;
                  $display("%0t: out_hi expected %h actual %h", $time, want[127:64],
                           got[127:64]);
               end
               if (want[63:0] != got[63:0]) begin
                  error_count++;
                  $display("%0t: out_lo expected %h actual %h", $time, want[63:0],
                           got[63:0]);
               end
            end
         end
      end
   end

endmodule

FILE: tb/tb_sp_block_cipher_128_encrypt_decrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block cipher testbench
// Drives key writes and encrypt/decrypt requests with random idling and a
// long response hold-off; the checker predicts each response and counts
// mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sp_block_cipher_128_encrypt_decrypt
   import sbc_pkg::*;
();

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [BLOCK_W-1:0]   req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [BLOCK_W-1:0]   rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_data;
   int                   error_count;
   int                   blocks_pending;

   // Random idling is turned off near the end of the run.
   bit                   idle_enable = 1'b1;
   // Set once to make the response side hold off for a long stretch.
   bit                   hold_off_request = 1'b0;

   sp_block_cipher_128_encrypt_decrypt u_top (.*);

   tb_sp_block_cipher_128_encrypt_decrypt_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Guard against a hung block: far beyond the slowest correct run.
   initial begin
      #20ms;
      $display("tb_sp_block_cipher_128_encrypt_decrypt: errors");
      $finish;
   end

   // Response side: random stalls in short bursts, plus one long hold-off
   // so that the block fills up and stops accepting requests.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(1, 4);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Write one key word and wait for the handshake.
   task automatic write_key(logic [CSR_IDX_W-1:0] index, logic [WORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Offer one request, with an optional idle burst ahead of it.
   task automatic send_block(bit decrypt, logic [WORD_W-1:0] hi, logic [WORD_W-1:0] lo);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= decrypt;
      req_tdata  <= {lo, hi};
      do @(posedge clock); while (!req_tready);
   endtask

   // Key writes only happen with nothing in flight.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (blocks_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic random_key();
      write_key(CSR_KEY_WORD0, random_word());
      write_key(CSR_KEY_WORD1, random_word());
      write_key(CSR_KEY_WORD2, random_word());
      write_key(CSR_KEY_WORD3, random_word());
   endtask

   initial begin
      logic [WORD_W-1:0] hi, lo;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Data before any key write uses the all-zero key schedule.
      send_block(1'b0, '0, '0);
      send_block(1'b1, '0, '0);
      send_block(1'b0, '1, '1);
      send_block(1'b1, '1, '1);
      drain();

      // The standard test key, then two indexes beyond the key words that
      // must change nothing.
      write_key(CSR_KEY_WORD0, 64'h8899aabbccddeeff);
      write_key(CSR_KEY_WORD1, 64'h0011223344556677);
      write_key(CSR_KEY_WORD2, 64'hfedcba9876543210);
      write_key(CSR_KEY_WORD3, 64'h0123456789abcdef);
      write_key(8'd4, '1);
      write_key(8'hff, 64'h5555555555555555);
      send_block(1'b0, 64'h1122334455667700, 64'hffeeddccbbaa9988);
      send_block(1'b1, 64'h7f679d90bebc2430, 64'h5a468d42b9d4edcd);
      send_block(1'b0, 64'h8000000000000001, 64'h8000000000000001);
      send_block(1'b1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      drain();

      // Extreme keys.
      write_key(CSR_KEY_WORD0, '1);
      write_key(CSR_KEY_WORD1, '1);
      write_key(CSR_KEY_WORD2, '1);
      write_key(CSR_KEY_WORD3, '1);
      send_block(1'b0, '0, '1);
      send_block(1'b1, '1, '0);
      drain();

      // Random part: a fresh key every phase, one phase with a long hold-off.
      for (int phase = 0; phase < 20; phase++) begin
         if (phase == 18) idle_enable = 1'b0;
         random_key();
         if (phase == 3) hold_off_request = 1'b1;
         for (int n = 0; n < 100; n++) begin
            hi = ($urandom_range(0, 15) == 0) ? random_word() : {$urandom, $urandom};
            lo = ($urandom_range(0, 15) == 0) ? random_word() : {$urandom, $urandom};
            send_block(1'($urandom_range(0, 1)), hi, lo);
         end
         drain();
      end

      if (error_count == 0) begin
         $display("tb_sp_block_cipher_128_encrypt_decrypt: clean");
      end else begin
         $display("tb_sp_block_cipher_128_encrypt_decrypt: errors");
      end
      $finish;
   end

endmodule

FILE: files.f
design/sbc_pkg.sv
design/sbc_ctrl.sv
design/sbc_datapath.sv
design/sp_block_cipher_128_encrypt_decrypt.sv
tb/tb_sp_block_cipher_128_encrypt_decrypt_checker.sv
tb/tb_sp_block_cipher_128_encrypt_decrypt.sv
